// ===== src/pgcs_pkg.sv =====
// shared types, constants and sizes for the packed grid cell store
`timescale 1ns / 1ps

package pgcs_pkg;

  localparam int unsigned CELL_BITS      = 2;
  localparam int unsigned STORE_BYTES    = 1024;
  localparam int unsigned CELLS_PER_BYTE = 8 / CELL_BITS;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W  = $clog2(STORE_BYTES + 1);
  localparam int unsigned OFF_W  = 3;

  localparam logic [7:0]       CELL_MASK = 8'((1 << CELL_BITS) - 1);
  localparam logic [IDX_W:0]   STORE_LIM = (IDX_W + 1)'(STORE_BYTES);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] col;
    logic [7:0] row;
    logic [1:0] cell_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] read_state;
    logic       status;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_addr;
    logic [OFF_W-1:0]  bit_off;
    logic              oob;
    logic [CNT_W-1:0]  clr_cnt;
  } loc_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } ram_req_t;

endpackage

// ===== src/pgcs_addr_gen.sv =====
// cell index to byte address, bit offset, bounds flag and clear length
`timescale 1ns / 1ps

module pgcs_addr_gen import pgcs_pkg::*; (
  input  logic [7:0] col,
  input  logic [7:0] row,
  input  logic [7:0] grid_width,
  input  logic [7:0] grid_height,
  output loc_t       loc
);

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] addr_full;
  logic [IDX_W-1:0] cells;
  logic [IDX_W:0]   cells_up;
  logic [IDX_W:0]   cnt_full;

  always_comb begin
    idx       = IDX_W'(row) * IDX_W'(grid_width) + IDX_W'(col);
    addr_full = IDX_W'(idx / CELLS_PER_BYTE);
    cells     = IDX_W'(grid_width) * IDX_W'(grid_height);
    cells_up  = {1'b0, cells} + (IDX_W + 1)'(CELLS_PER_BYTE - 1);
    cnt_full  = (IDX_W + 1)'(cells_up / CELLS_PER_BYTE);

    loc.byte_addr = addr_full[ADDR_W-1:0];
    loc.bit_off   = OFF_W'((idx % CELLS_PER_BYTE) * CELL_BITS);
    loc.oob       = ({1'b0, addr_full} >= STORE_LIM);
    loc.clr_cnt   = (cnt_full > STORE_LIM) ? CNT_W'(STORE_BYTES) : CNT_W'(cnt_full);
  end

endmodule

// ===== src/pgcs_byte_ram.sv =====
// byte-wide synchronous store holding the packed cells
`timescale 1ns / 1ps

module pgcs_byte_ram import pgcs_pkg::*; (
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/packed_grid_cell_store_unit.sv =====
// packed grid cell store: command control, read-modify-write and clear walk
//
//  channel  direction  handshake                 word
//  in_      input      start / busy              in_data  (in_word_t)
//  out_     output     out_strobe, one cycle     out_data (out_word_t)
//  cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// read, write and unused commands pass through the access state: the byte read is issued on
// the accept edge, then the result is registered and any write-back made in the access state.
// clear zeroes ceil(width*height/cells per byte) bytes, capped at the store,
// one byte zeroed per cycle through the single write port.
// the result word appears on the cycle after the last busy cycle.
// synchronous active-low reset; the receiver cannot stall the result.
`timescale 1ns / 1ps

module packed_grid_cell_store_unit import pgcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_strobe,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  state_t            state_r, state_nxt;
  logic [7:0]        grid_width_r, grid_height_r;
  logic [1:0]        cmd_r;
  logic [1:0]        val_r;
  logic [ADDR_W-1:0] addr_r;
  logic [OFF_W-1:0]  off_r;
  logic              oob_r;
  logic [CNT_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]  clr_ptr_r, clr_ptr_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_word_t         out_data_r, out_data_nxt;
  loc_t              loc;
  ram_req_t          ram_req;
  logic [7:0]        rd_data;
  logic [7:0]        field_mask;
  logic              is_rw;
  logic              accept;

  pgcs_addr_gen u_addr_gen (
    .col         (in_data.col),
    .row         (in_data.row),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .loc         (loc)
  );

  pgcs_byte_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  assign busy      = (state_r != ST_IDLE) || !rst_n;
  assign accept    = start && !busy;
  assign cfg_ready = rst_n;
  assign is_rw     = (in_data.command == CMD_READ) || (in_data.command == CMD_WRITE);
  assign field_mask = CELL_MASK << off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 8'd16;
      grid_height_r <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      clr_ptr_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r     <= in_data.command;
      val_r     <= in_data.cell_value;
      addr_r    <= loc.byte_addr;
      off_r     <= loc.bit_off;
      oob_r     <= is_rw && loc.oob;
      clr_cnt_r <= loc.clr_cnt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    clr_ptr_nxt     = clr_ptr_r;
    out_strobe_nxt  = 1'b0;
    out_data_nxt    = '0;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = loc.byte_addr;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = addr_r;
    ram_req.wr_data = (rd_data & ~field_mask) | ((8'(val_r) & CELL_MASK) << off_r);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ram_req.rd_en = is_rw && !loc.oob;
          state_nxt = (in_data.command == CMD_CLEAR) ? ST_CLEAR : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        ram_req.wr_en  = (cmd_r == CMD_WRITE) && !oob_r;
        out_strobe_nxt = 1'b1;
        out_data_nxt.status = oob_r;
        if ((cmd_r == CMD_READ) && !oob_r) begin
          out_data_nxt.read_state = 2'((rd_data >> off_r) & CELL_MASK);
        end
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (clr_ptr_r == clr_cnt_r) begin
          out_strobe_nxt = 1'b1;
          clr_ptr_nxt    = '0;
          state_nxt      = ST_IDLE;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = clr_ptr_r[ADDR_W-1:0];
          ram_req.wr_data = '0;
          clr_ptr_nxt     = clr_ptr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two cycles in a row");

  a_access_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.command != CMD_CLEAR) |-> ##2 out_strobe)
    else $error("cell access result missing two cycles after start");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status |-> out_data.read_state == 2'd0)
    else $error("dropped access returned a nonzero state");

  a_idle_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> clr_ptr_r == '0)
    else $error("clear pointer not back at zero when idle");

endmodule

// ===== verif/packed_grid_cell_store_unit_tb.sv =====
// self-checking testbench for the packed grid cell store unit
`timescale 1ns / 1ps

module packed_grid_cell_store_unit_tb;
  import pgcs_pkg::*;

  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  class cell_store_scoreboard;
    logic [7:0]  cell_bytes [STORE_BYTES];
    int unsigned grid_w;
    int unsigned grid_h;
    out_word_t   expected_replies[$];
    int          fails;

    function new();
      foreach (cell_bytes[i]) cell_bytes[i] = 8'h00;
      grid_w = 16;
      grid_h = 16;
      fails  = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_GRID_WIDTH:  grid_w = data;
        CFG_GRID_HEIGHT: grid_h = data;
        default: ;
      endcase
    endfunction

    // apply one accepted command word to the grid and queue its reply
    function void apply_command(in_word_t w);
      out_word_t   reply;
      int unsigned idx;
      int unsigned addr;
      int unsigned shift;
      int unsigned count;
      logic [7:0]  b;
      reply = '0;
      case (w.command)
        CMD_READ, CMD_WRITE: begin
          idx   = w.row * grid_w + w.col;
          addr  = idx / CELLS_PER_BYTE;
          shift = (idx % CELLS_PER_BYTE) * CELL_BITS;
          if (addr >= STORE_BYTES) begin
            reply.status = 1'b1;
          end else if (w.command == CMD_READ) begin
            b = (cell_bytes[addr] >> shift) & CELL_MASK;
            reply.read_state = b[1:0];
          end else begin
            b = cell_bytes[addr];
            b &= ~(CELL_MASK << shift);
            b |= ({6'd0, w.cell_value} & CELL_MASK) << shift;
            cell_bytes[addr] = b;
          end
        end
        CMD_CLEAR: begin
          count = (grid_w * grid_h + CELLS_PER_BYTE - 1) / CELLS_PER_BYTE;
          if (count > STORE_BYTES) count = STORE_BYTES;
          for (int unsigned i = 0; i < count; i++) cell_bytes[i] = 8'h00;
        end
        default: ;
      endcase
      expected_replies.push_back(reply);
    endfunction

    function void compare_result(out_word_t got);
      out_word_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected result word read_state=%0d status=%0d",
               got.read_state, got.status);
        fails++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.read_state !== want.read_state) begin
        $error("read_state expected %0d actual %0d", want.read_state, got.read_state);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_word_t   in_data   = '0;
  logic       out_strobe;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  cell_store_scoreboard sb = new();
  logic [15:0] recent_spots[$];

  int unsigned phase_w [12] = '{255, 1, 0, 16, 3, 200, 64, 255, 1, 0, 37, 255};
  int unsigned phase_h [12] = '{255, 1, 5, 16, 200, 3, 64, 1, 255, 0, 11, 16};

  packed_grid_cell_store_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.compare_result(out_data);
      if (start && !busy) sb.apply_command(in_data);
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
    end
  end

  initial begin
    #100_000_000;
    $display("packed_grid_cell_store_unit_tb failed");
    $finish;
  end

  function automatic in_word_t make_word(logic [1:0] cmd, logic [7:0] col, logic [7:0] row,
                                         logic [1:0] val);
    in_word_t w;
    w.command    = cmd;
    w.col        = col;
    w.row        = row;
    w.cell_value = val;
    return w;
  endfunction

  function automatic int unsigned gap_cycles();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly in-grid accesses, reads often revisit recently written cells
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned p;
    int unsigned wmax;
    int unsigned hmax;
    w = $bits(in_word_t)'($urandom);
    p = $urandom_range(0, 99);
    if (p < 44) w.command = CMD_WRITE;
    else if (p < 88) w.command = CMD_READ;
    else if (p < 92) w.command = CMD_CLEAR;
    else if (p < 96) w.command = CMD_SPARE;
    if ($urandom_range(0, 9) < 8) begin
      wmax = (sb.grid_w == 0) ? 255 : sb.grid_w - 1;
      hmax = (sb.grid_h == 0) ? 255 : sb.grid_h - 1;
      w.col = 8'($urandom_range(0, wmax));
      w.row = 8'($urandom_range(0, hmax));
    end
    if (w.command == CMD_READ && recent_spots.size() != 0 && $urandom_range(0, 1) == 1)
      {w.col, w.row} = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
    if (w.command == CMD_WRITE) begin
      recent_spots.push_back({w.col, w.row});
      if (recent_spots.size() > 16) void'(recent_spots.pop_front());
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= $bits(in_word_t)'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic put_item(in_word_t w);
    send_word(w);
    pause(gap_cycles());
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 8'($urandom);
  endtask

  initial begin
    logic burst;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-size grid: clear defines every byte of the store
    write_register(CFG_GRID_WIDTH, 8'd255);
    write_register(CFG_GRID_HEIGHT, 8'd255);
    write_register(CFG_SPARE_IDX, 8'hA5);
    put_item(make_word(CMD_CLEAR, 8'd0, 8'd0, 2'd0));
    put_item(make_word(CMD_WRITE, 8'd0, 8'd0, 2'd3));
    put_item(make_word(CMD_WRITE, 8'd1, 8'd0, 2'd1));
    put_item(make_word(CMD_WRITE, 8'd2, 8'd0, 2'd2));
    put_item(make_word(CMD_WRITE, 8'd3, 8'd0, 2'd3));
    put_item(make_word(CMD_READ, 8'd0, 8'd0, 2'd0));
    put_item(make_word(CMD_READ, 8'd1, 8'd0, 2'd3));
    put_item(make_word(CMD_READ, 8'd2, 8'd0, 2'd1));
    put_item(make_word(CMD_READ, 8'd3, 8'd0, 2'd2));
    // last byte of the store, then just beyond it
    put_item(make_word(CMD_WRITE, 8'd15, 8'd16, 2'd2));
    put_item(make_word(CMD_READ, 8'd15, 8'd16, 2'd0));
    put_item(make_word(CMD_WRITE, 8'd16, 8'd16, 2'd1));
    put_item(make_word(CMD_READ, 8'd16, 8'd16, 2'd0));
    put_item(make_word(CMD_WRITE, 8'd255, 8'd255, 2'd3));
    put_item(make_word(CMD_READ, 8'd255, 8'd255, 2'd3));
    put_item(make_word(CMD_SPARE, 8'd255, 8'd255, 2'd3));

    // zero dimensions: clear covers nothing, index reduces to the column
    settle();
    write_register(CFG_GRID_WIDTH, 8'd0);
    write_register(CFG_GRID_HEIGHT, 8'd0);
    put_item(make_word(CMD_CLEAR, 8'd0, 8'd0, 2'd0));
    put_item(make_word(CMD_READ, 8'd3, 8'd200, 2'd0));

    settle();
    write_register(CFG_GRID_WIDTH, 8'd1);
    write_register(CFG_GRID_HEIGHT, 8'd1);
    put_item(make_word(CMD_CLEAR, 8'd0, 8'd0, 2'd0));
    put_item(make_word(CMD_READ, 8'd0, 8'd0, 2'd0));
    put_item(make_word(CMD_READ, 8'd255, 8'd0, 2'd0));

    for (int phase = 0; phase < 12; phase++) begin
      settle();
      write_register(CFG_GRID_WIDTH, 8'(phase_w[phase]));
      write_register(CFG_GRID_HEIGHT, 8'(phase_h[phase]));
      recent_spots.delete();
      burst = (phase % 3 == 0);
      for (int n = 0; n < 94; n++) begin
        send_word(random_word());
        if (!burst) pause(gap_cycles());
        if ($urandom_range(0, 99) == 0) settle();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("packed_grid_cell_store_unit_tb passed");
    end else begin
      $display("packed_grid_cell_store_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pgcs_pkg.sv
src/pgcs_addr_gen.sv
src/pgcs_byte_ram.sv
src/packed_grid_cell_store_unit.sv
verif/packed_grid_cell_store_unit_tb.sv
